@@ rtl/buffer_pool_mru_manager_core_macros.svh @@
// assertion macros for the buffer pool frame manager
// used by the top level only
`ifndef BUFFER_POOL_MRU_MANAGER_CORE_MACROS_SVH
`define BUFFER_POOL_MRU_MANAGER_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define BPM_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bpm check failed");
// next-cycle implication
`define BPM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bpm check failed");
`endif

@@ rtl/bpm_pkg.sv @@
// shared types and codes of the buffer pool frame manager
// no dependencies
`timescale 1ns / 1ps
package bpm_pkg;
   localparam int NUM_FRAMES_DEF = 16;
   localparam int PIN_MAX = 255;
   localparam logic [1:0] OP_GET = 2'd0;
   localparam logic [1:0] OP_FREE = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [3:0] ST_HIT = 4'd0;
   localparam logic [3:0] ST_FILL = 4'd1;
   localparam logic [3:0] ST_EVICT = 4'd2;
   localparam logic [3:0] ST_NONE = 4'd3;
   localparam logic [3:0] ST_REL = 4'd4;
   localparam logic [3:0] ST_NOTFOUND = 4'd5;
   localparam logic [3:0] ST_NOTPIN = 4'd6;
   localparam logic [3:0] ST_FLWR = 4'd7;
   localparam logic [3:0] ST_FLDONE = 4'd8;
   // command from the sequencer to the list cells
   typedef struct packed {
      logic remove;   // drop matching frame, close the gap
      logic append;   // write frame at tail
      logic pop;      // drop tail
   } list_cmd_type;
endpackage

@@ rtl/buffer_pool_mru_manager_core.sv @@
// buffer pool frame manager: top level with frame table and list chain
// depends on bpm_pkg, bpm_list_cell and the macros header
// Usage: pulse start with req_ fields while busy is low. Each result sits on
// the rsp_ ports for one cycle with rsp_strobe high; the receiver cannot
// stall. Get and free pass through a lookup state and an update state and
// give one result, registered in the update state; busy is high in both
// states, so the next item waits for idle. Flush walks the frames one per
// cycle, giving one write-back word per dirty frame and a done word. The
// unused op is not accepted: busy stays low and it gives no word.
// The unpinned list is a chain of cells; a removal shifts every cell at or
// above the match down by one in the update cycle. csr_ writes frames_in_use
// (reset 16) and are ready whenever reset is low. Reset clears pin counts,
// dirty bits, and fill and list counts; tags and list slots are not cleared.
`timescale 1ns / 1ps
`include "buffer_pool_mru_manager_core_macros.svh"
module buffer_pool_mru_manager_core #(
   parameter int NUM_FRAMES = bpm_pkg::NUM_FRAMES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_op,
   input  logic [15:0] req_file_index,
   input  logic [15:0] req_page_index,
   input  logic req_mark_dirty,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [4:0] csr_data,
   output logic rsp_strobe,
   output logic [3:0] rsp_status,
   output logic [3:0] rsp_frame_index,
   output logic rsp_read_request,
   output logic rsp_write_back,
   output logic [15:0] rsp_victim_file,
   output logic [15:0] rsp_victim_page,
   output logic rsp_last_result
);
   localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CW = $clog2(NUM_FRAMES + 1);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_LOOK = 4'b0010, S_UPD = 4'b0100, S_FLUSH = 4'b1000
   } state_type;
   state_type state_ff, state_in;
   logic [15:0] tf_ff [NUM_FRAMES];
   logic [15:0] tp_ff [NUM_FRAMES];
   logic [7:0] pin_ff [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] dirty_ff;
   logic [CW-1:0] loaded_ff, ucnt_ff;
   logic [4:0] fiu_ff;
   logic [1:0] op_ff;
   logic [15:0] f_ff, p_ff;
   logic md_ff;
   logic hit_ff;
   logic [FW-1:0] hidx_ff;
   logic [CW-1:0] walk_ff;
   logic [NUM_FRAMES-1:0] hvec;
   logic [NUM_FRAMES-1:0] lmatch, gap;
   logic [FW-1:0] ldata [NUM_FRAMES];
   bpm_pkg::list_cmd_type cmd;
   logic [FW-1:0] key;
   logic [CW-1:0] usable;

   assign busy = state_ff != S_IDLE;
   assign csr_ready = !reset;

   // usable frames from the register
   always_comb begin
      if (fiu_ff == 5'd0) usable = CW'(1);
      else if (32'(fiu_ff) > NUM_FRAMES) usable = CW'(NUM_FRAMES);
      else usable = CW'(fiu_ff);
   end

   // tag compare over filled frames
   always_comb begin
      for (int i = 0; i < NUM_FRAMES; i++)
         hvec[i] = (CW'(i) < loaded_ff) && tf_ff[i] == f_ff && tp_ff[i] == p_ff;
   end

   // list chain
   assign gap[0] = lmatch[0];
   for (genvar g = 1; g < NUM_FRAMES; g++) begin : g_gap
      assign gap[g] = gap[g-1] | lmatch[g];
   end
   for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      bpm_list_cell #(.FW(FW)) u_cell (
         .clock(clock), .cmd(cmd), .key(key),
         .here_valid(CW'(g) < ucnt_ff), .is_tail(CW'(g) == ucnt_ff),
         .gap_below(gap[g]),
         .up_data(ldata[(g + 1 < NUM_FRAMES) ? g + 1 : g]),
         .data(ldata[g]), .match(lmatch[g]));
   end

   // sequencer and response
   logic pinz, miss_fill, miss_evict, free_ok;
   logic [FW-1:0] vic;
   always_comb begin
      pinz = pin_ff[hidx_ff] == 8'd0;
      miss_fill = loaded_ff < usable;
      miss_evict = ucnt_ff != CW'(0);
      vic = ldata[(ucnt_ff == CW'(0)) ? FW'(0) : FW'(ucnt_ff - CW'(1))];
      free_ok = hit_ff && !pinz;
      cmd = '0;
      key = hidx_ff;
      if (state_ff == S_UPD) begin
         if (op_ff == bpm_pkg::OP_GET) begin
            if (hit_ff) cmd.remove = pinz;
            else if (!miss_fill) cmd.pop = miss_evict;
         end else if (free_ok && pin_ff[hidx_ff] == 8'd1 &&
                      ucnt_ff < CW'(NUM_FRAMES)) begin
            cmd.append = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_strobe <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         fiu_ff <= 5'd16;
         loaded_ff <= '0;
         ucnt_ff <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < NUM_FRAMES; i++) pin_ff[i] <= 8'd0;
      end else begin
         if (csr_valid) fiu_ff <= csr_data;
         rsp_status <= bpm_pkg::ST_HIT;
         rsp_frame_index <= 4'd0;
         rsp_read_request <= 1'b0;
         rsp_write_back <= 1'b0;
         rsp_victim_file <= 16'd0;
         rsp_victim_page <= 16'd0;
         rsp_last_result <= 1'b1;
         unique case (state_ff)
            S_IDLE: if (start && req_op != bpm_pkg::OP_UNUSED) begin
               op_ff <= req_op; f_ff <= req_file_index;
               p_ff <= req_page_index; md_ff <= req_mark_dirty;
               walk_ff <= '0;
               state_ff <= (req_op == bpm_pkg::OP_FLUSH) ? S_FLUSH : S_LOOK;
            end
            S_LOOK: begin
               hit_ff <= |hvec;
               hidx_ff <= '0;
               for (int i = NUM_FRAMES - 1; i >= 0; i--)
                  if (hvec[i]) hidx_ff <= FW'(i);
               state_ff <= S_UPD;
            end
            S_UPD: begin
               rsp_strobe <= 1'b1;
               state_ff <= S_IDLE;
               if (op_ff == bpm_pkg::OP_GET) begin
                  if (hit_ff) begin
                     if (pinz) ucnt_ff <= ucnt_ff - CW'(1);
                     if (pin_ff[hidx_ff] != 8'(bpm_pkg::PIN_MAX))
                        pin_ff[hidx_ff] <= pin_ff[hidx_ff] + 8'd1;
                     rsp_status <= bpm_pkg::ST_HIT;
                     rsp_frame_index <= 4'(hidx_ff);
                  end else if (miss_fill) begin
                     tf_ff[FW'(loaded_ff)] <= f_ff; tp_ff[FW'(loaded_ff)] <= p_ff;
                     pin_ff[FW'(loaded_ff)] <= 8'd1;
                     dirty_ff[FW'(loaded_ff)] <= 1'b0;
                     loaded_ff <= loaded_ff + CW'(1);
                     rsp_status <= bpm_pkg::ST_FILL;
                     rsp_frame_index <= 4'(loaded_ff);
                     rsp_read_request <= 1'b1;
                  end else if (miss_evict) begin
                     ucnt_ff <= ucnt_ff - CW'(1);
                     tf_ff[vic] <= f_ff; tp_ff[vic] <= p_ff;
                     pin_ff[vic] <= 8'd1; dirty_ff[vic] <= 1'b0;
                     rsp_status <= bpm_pkg::ST_EVICT;
                     rsp_frame_index <= 4'(vic);
                     rsp_read_request <= 1'b1;
                     rsp_write_back <= dirty_ff[vic];
                     if (dirty_ff[vic]) begin
                        rsp_victim_file <= tf_ff[vic];
                        rsp_victim_page <= tp_ff[vic];
                     end
                  end else begin
                     rsp_status <= bpm_pkg::ST_NONE;
                  end
               end else if (!hit_ff) begin
                  rsp_status <= bpm_pkg::ST_NOTFOUND;
               end else if (pinz) begin
                  rsp_status <= bpm_pkg::ST_NOTPIN;
                  rsp_frame_index <= 4'(hidx_ff);
               end else begin
                  pin_ff[hidx_ff] <= pin_ff[hidx_ff] - 8'd1;
                  if (cmd.append) ucnt_ff <= ucnt_ff + CW'(1);
                  dirty_ff[hidx_ff] <= dirty_ff[hidx_ff] | md_ff;
                  rsp_status <= bpm_pkg::ST_REL;
                  rsp_frame_index <= 4'(hidx_ff);
               end
            end
            S_FLUSH: begin
               // walk one frame a cycle, then the done word
               if (walk_ff >= loaded_ff) begin
                  rsp_strobe <= 1'b1;
                  rsp_status <= bpm_pkg::ST_FLDONE;
                  state_ff <= S_IDLE;
               end else begin
                  if (dirty_ff[FW'(walk_ff)]) begin
                     rsp_strobe <= 1'b1;
                     rsp_status <= bpm_pkg::ST_FLWR;
                     rsp_frame_index <= 4'(walk_ff);
                     rsp_write_back <= 1'b1;
                     rsp_victim_file <= tf_ff[FW'(walk_ff)];
                     rsp_victim_page <= tp_ff[FW'(walk_ff)];
                     rsp_last_result <= 1'b0;
                     dirty_ff[FW'(walk_ff)] <= 1'b0;
                  end
                  walk_ff <= walk_ff + CW'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BPM_ASSERT_IMP(a_list_le_loaded, clock, reset, 1'b1, ucnt_ff <= loaded_ff)
   `BPM_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe && !rsp_last_result, busy)
   `BPM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy && req_op != bpm_pkg::OP_UNUSED, busy)
endmodule

@@ rtl/bpm_list_cell.sv @@
// one slot of the unpinned-frame list, shifts towards its lower neighbour
// depends on bpm_pkg
`timescale 1ns / 1ps
module bpm_list_cell #(parameter int FW = 4) (
   input  logic clock,
   input  bpm_pkg::list_cmd_type cmd,
   input  logic [FW-1:0] key,
   input  logic here_valid,      // slot lies below the count
   input  logic is_tail,         // slot equals count (append target)
   input  logic gap_below,       // a match sits at or below this slot
   input  logic [FW-1:0] up_data,
   output logic [FW-1:0] data,
   output logic match
);
   logic [FW-1:0] data_ff, data_in;
   assign data = data_ff;
   assign match = here_valid && data_ff == key;
   // slot update
   always_comb begin
      data_in = data_ff;
      if (cmd.remove && gap_below) data_in = up_data;
      if (cmd.append && is_tail) data_in = key;
   end
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end
endmodule

@@ tb/testbench.sv @@
// testbench for the buffer pool frame manager: directed and random commands
// predicts every result word in a behavioural copy of the frame table; needs bpm_pkg and the core
`timescale 1ns / 1ps
module testbench;

   localparam int NF = 16;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  frame;
      logic        rd;
      logic        wb;
      logic [15:0] vfile;
      logic [15:0] vpage;
      logic        last;
   } word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_op = '0;
   logic [15:0] req_file_index = '0;
   logic [15:0] req_page_index = '0;
   logic req_mark_dirty = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_data = '0;
   logic rsp_strobe;
   logic [3:0] rsp_status;
   logic [3:0] rsp_frame_index;
   logic rsp_read_request;
   logic rsp_write_back;
   logic [15:0] rsp_victim_file;
   logic [15:0] rsp_victim_page;
   logic rsp_last_result;

   buffer_pool_mru_manager_core DUT (.*);

   always #5 clock = ~clock;

   // shadow frame table
   logic [15:0] m_tag_file [NF];
   logic [15:0] m_tag_page [NF];
   logic [7:0]  m_pins [NF];
   logic        m_dirty [NF];
   logic [3:0]  m_order [NF];
   int          m_loaded;
   int          m_unpinned;
   logic [4:0]  m_frames_reg;

   word_type expected_words [$];
   int errors = 0;
   int words_seen = 0;
   int items_sent = 0;
   bit no_idle = 1'b0;

   function automatic void push_word(logic [3:0] st, logic [3:0] fr, logic rd, logic wb,
                                     logic [15:0] vf, logic [15:0] vp, logic last);
      word_type w;
      w.status = st; w.frame = fr; w.rd = rd; w.wb = wb;
      w.vfile = vf; w.vpage = vp; w.last = last;
      expected_words.push_back(w);
   endfunction

   function automatic int find_frame(logic [15:0] f, logic [15:0] p);
      for (int i = 0; i < m_loaded; i++)
         if (m_tag_file[i] == f && m_tag_page[i] == p) return i;
      return -1;
   endfunction

   // compute the words caused by one command and update the shadow table
   function automatic void predict_command(logic [1:0] op, logic [15:0] f, logic [15:0] p,
                                           logic md);
      int hit;
      int lim;
      int v;
      int pos;
      lim = (m_frames_reg == 5'd0) ? 1 :
            ((int'(m_frames_reg) > NF) ? NF : int'(m_frames_reg));
      hit = find_frame(f, p);
      case (op)
         bpm_pkg::OP_GET: begin
            if (hit >= 0) begin
               if (m_pins[hit] == 8'd0) begin
                  pos = -1;
                  for (int i = 0; i < m_unpinned; i++)
                     if (pos < 0 && m_order[i] == 4'(hit)) pos = i;
                  if (pos >= 0) begin
                     for (int j = pos; j + 1 < m_unpinned; j++) m_order[j] = m_order[j + 1];
                     m_unpinned--;
                  end
               end
               if (m_pins[hit] < 8'(bpm_pkg::PIN_MAX)) m_pins[hit]++;
               push_word(bpm_pkg::ST_HIT, 4'(hit), 1'b0, 1'b0, 16'h0, 16'h0, 1'b1);
            end else if (m_loaded < lim) begin
               v = m_loaded;
               m_tag_file[v] = f; m_tag_page[v] = p; m_pins[v] = 8'd1; m_dirty[v] = 1'b0;
               m_loaded++;
               push_word(bpm_pkg::ST_FILL, 4'(v), 1'b1, 1'b0, 16'h0, 16'h0, 1'b1);
            end else if (m_unpinned > 0) begin
               v = int'(m_order[m_unpinned - 1]);
               m_unpinned--;
               if (m_dirty[v])
                  push_word(bpm_pkg::ST_EVICT, 4'(v), 1'b1, 1'b1, m_tag_file[v],
                            m_tag_page[v], 1'b1);
               else
                  push_word(bpm_pkg::ST_EVICT, 4'(v), 1'b1, 1'b0, 16'h0, 16'h0, 1'b1);
               m_tag_file[v] = f; m_tag_page[v] = p; m_pins[v] = 8'd1; m_dirty[v] = 1'b0;
            end else begin
               push_word(bpm_pkg::ST_NONE, 4'd0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1);
            end
         end
         bpm_pkg::OP_FREE: begin
            if (hit < 0)
               push_word(bpm_pkg::ST_NOTFOUND, 4'd0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1);
            else if (m_pins[hit] == 8'd0)
               push_word(bpm_pkg::ST_NOTPIN, 4'(hit), 1'b0, 1'b0, 16'h0, 16'h0, 1'b1);
            else begin
               m_pins[hit]--;
               if (m_pins[hit] == 8'd0 && m_unpinned < NF) begin
                  m_order[m_unpinned] = 4'(hit);
                  m_unpinned++;
               end
               m_dirty[hit] = m_dirty[hit] | md;
               push_word(bpm_pkg::ST_REL, 4'(hit), 1'b0, 1'b0, 16'h0, 16'h0, 1'b1);
            end
         end
         bpm_pkg::OP_FLUSH: begin
            for (int i = 0; i < m_loaded; i++)
               if (m_dirty[i]) begin
                  push_word(bpm_pkg::ST_FLWR, 4'(i), 1'b0, 1'b1, m_tag_file[i],
                            m_tag_page[i], 1'b0);
                  m_dirty[i] = 1'b0;
               end
            push_word(bpm_pkg::ST_FLDONE, 4'd0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // compare every result word with the oldest expectation
   always @(posedge clock) begin
      word_type got;
      word_type exp_w;
      if (!reset && rsp_strobe) begin
         got = {rsp_status, rsp_frame_index, rsp_read_request, rsp_write_back,
                rsp_victim_file, rsp_victim_page, rsp_last_result};
         words_seen++;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            errors++;
         end else begin
            exp_w = expected_words.pop_front();
            if (got.status !== exp_w.status)
               $display("%0t: status expected %0d actual %0d", $time, exp_w.status, got.status);
            if (got.frame !== exp_w.frame)
               $display("%0t: frame expected %0d actual %0d", $time, exp_w.frame, got.frame);
            if (got.rd !== exp_w.rd)
               $display("%0t: read_request expected %b actual %b", $time, exp_w.rd, got.rd);
            if (got.wb !== exp_w.wb)
               $display("%0t: write_back expected %b actual %b", $time, exp_w.wb, got.wb);
            if (got.vfile !== exp_w.vfile)
               $display("%0t: victim_file expected %h actual %h", $time, exp_w.vfile, got.vfile);
            if (got.vpage !== exp_w.vpage)
               $display("%0t: victim_page expected %h actual %h", $time, exp_w.vpage, got.vpage);
            if (got.last !== exp_w.last)
               $display("%0t: last_result expected %b actual %b", $time, exp_w.last, got.last);
            if (got !== exp_w) errors++;
         end
      end
   end

   // send one command word, with random idle cycles ahead of it
   task automatic send_command(logic [1:0] op, logic [15:0] f, logic [15:0] p, logic md);
      while (!no_idle && $urandom_range(99) < 9) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_op <= op; req_file_index <= f; req_page_index <= p; req_mark_dirty <= md;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_command(op, f, p, md);
      items_sent++;
   endtask

   // stop sending, wait for every expected word, then let the block settle
   task automatic drain;
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_frames_reg(logic [4:0] value);
      drain();
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      m_frames_reg = value;
   endtask

   // extremes of the fields, every operation and the named corner cases
   task automatic test_directed;
      send_command(bpm_pkg::OP_FREE, 16'h0, 16'h0, 1'b1);          // free of uncached page
      send_command(bpm_pkg::OP_FLUSH, 16'h0, 16'h0, 1'b0);         // flush with nothing dirty
      send_command(bpm_pkg::OP_GET, 16'hFFFF, 16'hFFFF, 1'b0);     // fill
      send_command(bpm_pkg::OP_GET, 16'hFFFF, 16'hFFFF, 1'b0);     // hit
      send_command(bpm_pkg::OP_FREE, 16'hFFFF, 16'hFFFF, 1'b1);
      send_command(bpm_pkg::OP_FREE, 16'hFFFF, 16'hFFFF, 1'b1);
      send_command(bpm_pkg::OP_FREE, 16'hFFFF, 16'hFFFF, 1'b0);    // not pinned
      send_command(bpm_pkg::OP_UNUSED, 16'h1234, 16'h5678, 1'b1);  // unused op, ignored
      send_command(bpm_pkg::OP_GET, 16'h0000, 16'h0000, 1'b1);
      send_command(bpm_pkg::OP_FREE, 16'h0000, 16'h0000, 1'b1);
      send_command(bpm_pkg::OP_FLUSH, 16'h0, 16'h0, 1'b1);
      write_frames_reg(5'd2);                                      // equal to the filled count
      send_command(bpm_pkg::OP_GET, 16'hAAAA, 16'h5555, 1'b0);     // eviction of clean mru
      send_command(bpm_pkg::OP_GET, 16'h5555, 16'hAAAA, 1'b0);     // eviction of the last unpinned frame
      send_command(bpm_pkg::OP_FREE, 16'hAAAA, 16'h5555, 1'b1);
      send_command(bpm_pkg::OP_GET, 16'h0001, 16'h0002, 1'b0);     // dirty eviction
      write_frames_reg(5'd0);                                      // acts as one
      send_command(bpm_pkg::OP_GET, 16'h0003, 16'h0004, 1'b0);
      write_frames_reg(5'd31);                                     // above the pool size
   endtask

   // random traffic over a small page set so hits and evictions are common
   task automatic test_random(int count, logic [4:0] frames);
      logic [1:0] op;
      logic [15:0] f;
      logic [15:0] p;
      int r;
      write_frames_reg(frames);
      for (int i = 0; i < count; i++) begin
         r = int'($urandom_range(99));
         op = (r < 50) ? bpm_pkg::OP_GET : (r < 90) ? bpm_pkg::OP_FREE :
              (r < 97) ? bpm_pkg::OP_FLUSH : bpm_pkg::OP_UNUSED;
         if ($urandom_range(9) == 0) begin
            f = 16'($urandom); p = 16'($urandom);
         end else begin
            f = {1'($urandom_range(1)), 14'h0, 1'($urandom_range(1))};
            p = {1'($urandom_range(1)), 12'h0, 3'($urandom_range(7))};
         end
         send_command(op, f, p, 1'($urandom_range(1)));
         if (i == count / 2) drain();                  // hold off until all words arrive
      end
   endtask

   initial begin
      for (int i = 0; i < NF; i++) begin
         m_pins[i] = 8'd0; m_dirty[i] = 1'b0; m_tag_file[i] = 16'h0; m_tag_page[i] = 16'h0;
         m_order[i] = 4'd0;
      end
      m_loaded = 0; m_unpinned = 0; m_frames_reg = 5'd16;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(50, 5'd4);
      no_idle = 1'b1;
      test_random(50, 5'd16);
      no_idle = 1'b0;
      test_random(50, 5'd1);
      test_random(50, 5'd9);
      drain();
      $display("covered %0d commands and %0d result words over several pool sizes,",
               items_sent, words_seen);
      $display("including evictions, flushes, a lowered frame count and error statuses");
      if (errors == 0 && expected_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl
rtl/bpm_pkg.sv
rtl/bpm_list_cell.sv
rtl/buffer_pool_mru_manager_core.sv
tb/testbench.sv
